// ===== rtl/particle_swarm_update_engine_defines.svh =====
// Assertion macros shared by the RTL
`ifndef PARTICLE_SWARM_UPDATE_ENGINE_DEFINES_SVH
`define PARTICLE_SWARM_UPDATE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PSUE_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PSUE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSUE_ASSERT(label, clk, rst_n, ante, cons)
`define PSUE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/psue_pkg.sv =====
`default_nettype none
package psue_pkg;
    localparam int NUM_PARTICLES  = 16;
    localparam int NUM_DIMENSIONS = 8;
    localparam int PART_W  = 4;
    localparam int DIM_W   = 3;
    localparam int SLOT_W  = PART_W + DIM_W;
    localparam int SLOTS   = NUM_PARTICLES * NUM_DIMENSIONS;
    localparam int NUM_ELEMS = 8;

    // command codes (tuser on the input side)
    localparam logic [1:0] CMD_BOUNDS = 2'd0;
    localparam logic [1:0] CMD_RAND   = 2'd1;
    localparam logic [1:0] CMD_OBJ    = 2'd2;

    // result kinds (tuser on the output side)
    localparam logic [1:0] KIND_COORD  = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_FINAL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_INERTIA   = 3'd0;
    localparam logic [2:0] REG_COG_GAIN  = 3'd1;
    localparam logic [2:0] REG_SOC_GAIN  = 3'd2;
    localparam logic [2:0] REG_TOLERANCE = 3'd3;
    localparam logic [2:0] REG_ITER_LIM  = 3'd4;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_MI   = 15'b000000000000010,
        S_MA1  = 15'b000000000000100,
        S_MA2  = 15'b000000000001000,
        S_MV   = 15'b000000000010000,
        S_MT1  = 15'b000000000100000,
        S_MT2  = 15'b000000001000000,
        S_SUM  = 15'b000000010000000,
        S_UPD  = 15'b000000100000000,
        S_OBJ  = 15'b000001000000000,
        S_CRD  = 15'b000010000000000,
        S_CWR  = 15'b000100000000000,
        S_END  = 15'b001000000000000,
        S_REP  = 15'b010000000000000,
        S_ELEM = 15'b100000000000000
    } t_state;

    // saturate a 40-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sh007FFFFFFF) r = 32'sh7FFFFFFF;
        else if (x < -40'sh0080000000) r = -32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/psue_ram.sv =====
`default_nettype none
module psue_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/particle_swarm_update_engine.sv =====
// A coordinate init runs S_MI, S_UPD; an update S_MA1 to S_SUM, S_UPD; an objective
//   S_OBJ, on improvement an S_CRD/S_CWR copy per dimension, S_END, plus the report
//   and up to 8 best-position beats at one per cycle when the sink is ready.
// One item at a time: one shared 19x34 multiplier and the position RAM port set the
//   pace of each item. Synchronous active-low reset; the stores for positions,
//   velocities and personal bests are not cleared.
`default_nettype none
`include "particle_swarm_update_engine_defines.svh"
module particle_swarm_update_engine (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write port
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // dimension[2:0] lower_bound[34:3] upper_bound[66:35] rand_first[82:67]
    // rand_second[98:83] objective_value[130:99]
    input  wire logic [135:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // particle_index[3:0] coord_index[6:4] coordinate[38:7] best_obj[70:39]
    // converged[71] iterations[87:72] finished[88]
    output logic [95:0]       m_axis_tdata,
    // kind[1:0]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    localparam int ND = psue_pkg::NUM_DIMENSIONS;

    // config registers
    logic [17:0]        r_inertia, r_cog, r_soc;
    logic signed [31:0] r_tol;
    logic [15:0]        r_lim;

    // control state
    psue_pkg::t_state                 r_state;
    logic [psue_pkg::PART_W-1:0]      r_pcnt;
    logic [psue_pkg::DIM_W-1:0]       r_dcnt;
    logic [psue_pkg::DIM_W-1:0]       r_cnt;
    logic [15:0]                      r_iter;
    logic                             r_init, r_done, r_await;
    logic                             r_upd_p, r_upd_g, r_conv, r_fin;

    // datapath
    logic [15:0]        r_r1, r_r2;
    logic signed [31:0] r_obj;
    logic [17:0]        r_a1, r_a2;
    logic signed [39:0] r_acc;
    logic signed [52:0] r_prod;
    logic signed [31:0] r_lo [ND];
    logic signed [31:0] r_hi [ND];
    logic signed [31:0] r_gb [ND];
    logic signed [31:0] r_gbv;
    logic signed [31:0] r_pbv [psue_pkg::NUM_PARTICLES];

    // output register
    logic        r_ovalid, r_olast, r_oconv, r_ofin;
    logic [1:0]  r_okind;
    logic [3:0]  r_opidx;
    logic [2:0]  r_ocidx;
    logic [31:0] r_ocoord, r_obest;
    logic [15:0] r_oiter;

    // input fields
    logic [1:0]         in_cmd;
    logic [2:0]         in_dim;
    logic signed [31:0] in_lo, in_hi, in_obj;
    logic [15:0]        in_r1, in_r2;
    assign in_cmd = s_axis_tuser;
    assign in_dim = s_axis_tdata[2:0];
    assign in_lo  = s_axis_tdata[34:3];
    assign in_hi  = s_axis_tdata[66:35];
    assign in_r1  = s_axis_tdata[82:67];
    assign in_r2  = s_axis_tdata[98:83];
    assign in_obj = s_axis_tdata[130:99];

    logic accept, acc_coord, acc_obj, out_free;
    assign s_axis_tready = (r_state == psue_pkg::S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign acc_coord = accept && in_cmd == psue_pkg::CMD_RAND && !r_done && !r_await;
    assign acc_obj   = accept && in_cmd == psue_pkg::CMD_OBJ && !r_done && r_await;
    assign out_free  = !r_ovalid || m_axis_tready;

    // RAMs for positions, velocities and personal best positions
    logic [psue_pkg::SLOT_W-1:0] slot, pos_raddr, copy_slot;
    logic signed [31:0] pos_rd, vel_rd, pb_rd;
    logic               pos_we, vel_we, pb_we, pos_re;
    logic signed [31:0] x_new, v_new, pb_wdata;
    logic [psue_pkg::SLOT_W-1:0] pb_waddr;

    assign slot      = {r_pcnt, r_dcnt};
    assign copy_slot = {r_pcnt, r_cnt};
    assign pos_raddr = (r_state == psue_pkg::S_CRD) ? copy_slot : slot;
    assign pos_re    = acc_coord || (r_state == psue_pkg::S_CRD);

    psue_ram #(.WIDTH(32), .DEPTH(psue_pkg::SLOTS)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(slot), .i_wdata(x_new),
        .i_re(pos_re), .i_raddr(pos_raddr), .o_rdata(pos_rd));
    psue_ram #(.WIDTH(32), .DEPTH(psue_pkg::SLOTS)) u_vel (
        .i_clk(i_clk), .i_we(vel_we), .i_waddr(slot), .i_wdata(v_new),
        .i_re(acc_coord), .i_raddr(slot), .o_rdata(vel_rd));
    psue_ram #(.WIDTH(32), .DEPTH(psue_pkg::SLOTS)) u_pbest (
        .i_clk(i_clk), .i_we(pb_we), .i_waddr(pb_waddr), .i_wdata(pb_wdata),
        .i_re(acc_coord), .i_raddr(slot), .o_rdata(pb_rd));

    // shared multiplier operand select
    logic signed [18:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [36:0] prod_sh;
    logic signed [31:0] cur_lo, cur_hi, cur_gb;
    assign prod_sh = r_prod[52:16];
    assign cur_lo  = r_lo[r_dcnt];
    assign cur_hi  = r_hi[r_dcnt];
    assign cur_gb  = r_gb[r_dcnt];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (1'b1)
            r_state[1]: begin  // S_MI
                mul_a = {3'b0, r_r1};
                mul_b = {{2{cur_hi[31]}}, cur_hi} - {{2{cur_lo[31]}}, cur_lo};
            end
            r_state[2]: begin  // S_MA1
                mul_a = {1'b0, r_cog};
                mul_b = {18'b0, r_r1};
            end
            r_state[3]: begin  // S_MA2
                mul_a = {1'b0, r_soc};
                mul_b = {18'b0, r_r2};
            end
            r_state[4]: begin  // S_MV
                mul_a = {1'b0, r_inertia};
                mul_b = {{2{vel_rd[31]}}, vel_rd};
            end
            r_state[5]: begin  // S_MT1
                mul_a = {1'b0, r_a1};
                mul_b = {{2{pb_rd[31]}}, pb_rd} - {{2{pos_rd[31]}}, pos_rd};
            end
            r_state[6]: begin  // S_MT2
                mul_a = {1'b0, r_a2};
                mul_b = {{2{cur_gb[31]}}, cur_gb} - {{2{pos_rd[31]}}, pos_rd};
            end
            default: ;
        endcase
    end

    // new coordinate and velocity
    logic signed [31:0] v_run, x_sum, x_init;
    always_comb begin
        v_run  = psue_pkg::sat32(r_acc);
        x_sum  = psue_pkg::sat32({{8{pos_rd[31]}}, pos_rd} + {{8{v_run[31]}}, v_run});
        x_init = psue_pkg::sat32({{8{cur_lo[31]}}, cur_lo} + {{3{prod_sh[36]}}, prod_sh});
        if (r_init) begin
            x_new = x_init;
            v_new = {15'b0, r_r2, 1'b0} - 32'sd65536;
        end else begin
            x_new = x_sum;
            if (x_new < cur_lo) x_new = cur_lo;
            if (x_new > cur_hi) x_new = cur_hi;
            v_new = v_run;
        end
    end

    logic upd_fire;
    assign upd_fire = (r_state == psue_pkg::S_UPD) && out_free;
    assign pos_we   = upd_fire;
    assign vel_we   = upd_fire;
    assign pb_we    = (upd_fire && r_init) || (r_state == psue_pkg::S_CWR && r_upd_p);
    assign pb_waddr = (r_state == psue_pkg::S_CWR) ? copy_slot : slot;
    assign pb_wdata = (r_state == psue_pkg::S_CWR) ? pos_rd : x_new;

    // a result beat is loaded into the output register
    logic out_load;
    assign out_load = out_free && (r_state == psue_pkg::S_UPD || r_state == psue_pkg::S_REP
                                   || r_state == psue_pkg::S_ELEM);

    // objective compare and end-of-pass decisions
    logic        obj_p, obj_g, end_conv, end_fin, last_p;
    logic [15:0] iter_inc;
    assign obj_p    = r_init || (r_obj < r_pbv[r_pcnt]);
    assign obj_g    = r_obj < r_gbv;
    assign end_conv = r_gbv < r_tol;
    assign iter_inc = r_iter + 16'd1;
    assign last_p   = (r_pcnt == psue_pkg::PART_W'(psue_pkg::NUM_PARTICLES - 1));
    assign end_fin  = r_init ? (r_lim == 16'd0) : (end_conv || iter_inc >= r_lim);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inertia <= 18'd47186;
            r_cog     <= 18'd98304;
            r_soc     <= 18'd98304;
            r_tol     <= '0;
            r_lim     <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                psue_pkg::REG_INERTIA:   r_inertia <= i_cfg_data[17:0];
                psue_pkg::REG_COG_GAIN:  r_cog     <= i_cfg_data[17:0];
                psue_pkg::REG_SOC_GAIN:  r_soc     <= i_cfg_data[17:0];
                psue_pkg::REG_TOLERANCE: r_tol     <= i_cfg_data;
                psue_pkg::REG_ITER_LIM:  r_lim     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // datapath registers without reset; the product holds while the update waits
    always_ff @(posedge i_clk) begin
        if (r_state != psue_pkg::S_UPD) r_prod <= mul_a * mul_b;
        if (accept) begin
            r_r1  <= in_r1;
            r_r2  <= in_r2;
            r_obj <= in_obj;
        end
        if (r_state == psue_pkg::S_MA2) r_a1 <= prod_sh[17:0];
        if (r_state == psue_pkg::S_MV)  r_a2 <= prod_sh[17:0];
        if (r_state == psue_pkg::S_MT1) r_acc <= {{3{prod_sh[36]}}, prod_sh};
        if (r_state == psue_pkg::S_MT2 || r_state == psue_pkg::S_SUM)
            r_acc <= r_acc + {{3{prod_sh[36]}}, prod_sh};
        if (r_state == psue_pkg::S_OBJ && obj_p) r_pbv[r_pcnt] <= r_obj;
    end

    // sequencer, stores with reset values and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psue_pkg::S_IDLE;
            r_pcnt   <= '0;
            r_dcnt   <= '0;
            r_cnt    <= '0;
            r_iter   <= '0;
            r_init   <= 1'b1;
            r_done   <= 1'b0;
            r_await  <= 1'b0;
            r_upd_p  <= 1'b0;
            r_upd_g  <= 1'b0;
            r_conv   <= 1'b0;
            r_fin    <= 1'b0;
            r_gbv    <= 32'sh7FFFFFFF;
            r_ovalid <= 1'b0;
            for (int i = 0; i < ND; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
                r_gb[i] <= '0;
            end
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                psue_pkg::S_IDLE: begin
                    if (accept && in_cmd == psue_pkg::CMD_BOUNDS
                        && {1'b0, in_dim} < 4'(ND)) begin
                        r_lo[in_dim[psue_pkg::DIM_W-1:0]] <= in_lo;
                        r_hi[in_dim[psue_pkg::DIM_W-1:0]] <= in_hi;
                    end
                    if (acc_coord) r_state <= r_init ? psue_pkg::S_MI : psue_pkg::S_MA1;
                    if (acc_obj)   r_state <= psue_pkg::S_OBJ;
                end
                psue_pkg::S_MI:  r_state <= psue_pkg::S_UPD;
                psue_pkg::S_MA1: r_state <= psue_pkg::S_MA2;
                psue_pkg::S_MA2: r_state <= psue_pkg::S_MV;
                psue_pkg::S_MV:  r_state <= psue_pkg::S_MT1;
                psue_pkg::S_MT1: r_state <= psue_pkg::S_MT2;
                psue_pkg::S_MT2: r_state <= psue_pkg::S_SUM;
                psue_pkg::S_SUM: r_state <= psue_pkg::S_UPD;
                psue_pkg::S_UPD: begin
                    if (out_free) begin
                        r_okind  <= psue_pkg::KIND_COORD;
                        r_opidx  <= r_pcnt;
                        r_ocidx  <= r_dcnt;
                        r_ocoord <= x_new;
                        r_obest  <= r_gbv;
                        r_oconv  <= 1'b0;
                        r_oiter  <= r_iter;
                        r_ofin   <= 1'b0;
                        r_olast  <= (r_dcnt == psue_pkg::DIM_W'(ND - 1));
                        if (r_dcnt == psue_pkg::DIM_W'(ND - 1)) begin
                            r_dcnt  <= '0;
                            r_await <= 1'b1;
                        end else begin
                            r_dcnt <= r_dcnt + 1'b1;
                        end
                        r_state <= psue_pkg::S_IDLE;
                    end
                end
                psue_pkg::S_OBJ: begin
                    r_await <= 1'b0;
                    r_upd_p <= obj_p;
                    r_upd_g <= obj_g;
                    if (obj_g) r_gbv <= r_obj;
                    r_cnt   <= '0;
                    r_state <= (obj_p || obj_g) ? psue_pkg::S_CRD : psue_pkg::S_END;
                end
                psue_pkg::S_CRD: r_state <= psue_pkg::S_CWR;
                psue_pkg::S_CWR: begin
                    if (r_upd_g) r_gb[r_cnt] <= pos_rd;
                    r_cnt <= r_cnt + 1'b1;
                    r_state <= (r_cnt == psue_pkg::DIM_W'(ND - 1)) ?
                               psue_pkg::S_END : psue_pkg::S_CRD;
                end
                psue_pkg::S_END: begin
                    if (!last_p) begin
                        r_pcnt  <= r_pcnt + 1'b1;
                        r_state <= psue_pkg::S_IDLE;
                    end else begin
                        r_pcnt <= '0;
                        r_conv <= end_conv;
                        r_fin  <= end_fin;
                        r_init <= 1'b0;
                        if (!r_init && !end_conv) r_iter <= iter_inc;
                        r_state <= (r_init && !end_fin) ? psue_pkg::S_IDLE : psue_pkg::S_REP;
                    end
                end
                psue_pkg::S_REP: begin
                    if (out_free) begin
                        r_okind  <= psue_pkg::KIND_REPORT;
                        r_opidx  <= '0;
                        r_ocidx  <= '0;
                        r_ocoord <= '0;
                        r_obest  <= r_gbv;
                        r_oconv  <= r_conv;
                        r_oiter  <= r_iter;
                        r_ofin   <= r_fin;
                        r_olast  <= 1'b0;
                        r_cnt    <= '0;
                        if (r_fin) r_done <= 1'b1;
                        r_state <= r_fin ? psue_pkg::S_ELEM : psue_pkg::S_IDLE;
                    end
                end
                psue_pkg::S_ELEM: begin
                    if (out_free) begin
                        r_okind  <= psue_pkg::KIND_FINAL;
                        r_opidx  <= '0;
                        r_ocidx  <= r_cnt;
                        r_ocoord <= r_gb[r_cnt];
                        r_obest  <= r_gbv;
                        r_oconv  <= r_conv;
                        r_oiter  <= r_iter;
                        r_ofin   <= 1'b1;
                        r_olast  <= (r_cnt == psue_pkg::DIM_W'(ND - 1));
                        r_cnt    <= r_cnt + 1'b1;
                        if (r_cnt == psue_pkg::DIM_W'(ND - 1)) r_state <= psue_pkg::S_IDLE;
                    end
                end
                default: r_state <= psue_pkg::S_IDLE;
            endcase
        end
    end

    // output stream
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {7'b0, r_ofin, r_oiter, r_oconv, r_obest, r_ocoord,
                            r_ocidx, r_opidx};

    // checks
    `PSUE_ASSERT(a_await_dim0, i_clk, i_rst_n, r_await, r_dcnt == '0)
    `PSUE_ASSERT_NEXT(a_busy_after_coord, i_clk, i_rst_n, acc_coord, !s_axis_tready)
    `PSUE_ASSERT(a_done_no_coord, i_clk, i_rst_n, r_done && r_state == psue_pkg::S_IDLE, !(r_ovalid && r_okind == psue_pkg::KIND_COORD))
endmodule
`default_nettype wire
